// File: rtl/dc_motor_speed_model_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the DC motor speed model
// Concurrent checks on clk_i, with and without the reset disable.
// ----------------------------------------------------------------------------
`ifndef DC_MOTOR_SPEED_MODEL_UNIT_ASSERT_SVH
`define DC_MOTOR_SPEED_MODEL_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// check prop on every rising edge outside reset
`define DCMSM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// check prop on every rising edge, reset included
`define DCMSM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define DCMSM_ASSERT(lbl, prop, msg)
`define DCMSM_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// File: rtl/dcmsm_pkg.sv
// ----------------------------------------------------------------------------
// DC motor speed model package
// Widths, register indexes, reset values and shared types.
// ----------------------------------------------------------------------------
package dcmsm_pkg;

  localparam int SAMPLE_BITS = 12;

  localparam int SPEED_W   = 32;
  localparam int ANGLE_W   = 48;
  localparam int GAIN_W    = 32;
  localparam int DRIVE_W   = 24;
  localparam int LOAD_W    = 24;
  localparam int AGAIN_W   = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 32;

  // Q.50 accumulation width for the speed sum
  localparam int SUM_W     = 67;
  // drive product: unsigned gain times signed sample difference
  localparam int DIFF_W    = SAMPLE_BITS + 1;
  localparam int DRV_W     = DRIVE_W + 1 + DIFF_W;
  // angle product: unsigned gain times signed speed
  localparam int PROD_W    = AGAIN_W + 1 + SPEED_W;

  localparam logic signed [SUM_W-1:0]  SPD_RND  = SUM_W'(64'sd536870912);
  localparam logic signed [PROD_W-1:0] ANG_RND  = PROD_W'(64'sd2147483648);

  localparam logic signed [SPEED_W-1:0] SPEED_MAX = 32'sh7fff_ffff;
  localparam logic signed [SPEED_W-1:0] SPEED_MIN = 32'sh8000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FB_GAIN_ONE = 3'd0,
    REG_FB_GAIN_TWO = 3'd1,
    REG_DRIVE_GAIN  = 3'd2,
    REG_LOAD_OFFSET = 3'd3,
    REG_ANGLE_GAIN  = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic signed [GAIN_W-1:0] feedback_gain_one;
    logic signed [GAIN_W-1:0] feedback_gain_two;
    logic [DRIVE_W-1:0]       drive_gain;
    logic [LOAD_W-1:0]        load_offset;
    logic [AGAIN_W-1:0]       angle_gain;
  } cfg_regs_t;

  localparam cfg_regs_t CFG_RESET = '{
    feedback_gain_one: 32'sd2143518856,
    feedback_gain_two: -32'sd1069778358,
    drive_gain:        24'd108960,
    load_offset:       24'd1548,
    angle_gain:        32'd293203000
  };

  // handshake between the speed stage and the angle stage
  typedef struct packed {
    logic                      valid;
    logic signed [SPEED_W-1:0] speed;
  } spd_req_t;

endpackage

// File: rtl/dcmsm_smp_if.sv
// ----------------------------------------------------------------------------
// Sample channel
// Terminal voltage sample pair with valid/ready.
// ----------------------------------------------------------------------------
interface dcmsm_smp_if;
  import dcmsm_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] pos_sample;
  logic [SAMPLE_BITS-1:0] neg_sample;

  modport source (output valid, output pos_sample, output neg_sample, input ready);
  modport sink   (input valid, input pos_sample, input neg_sample, output ready);
endinterface

// File: rtl/dcmsm_res_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Speed and shaft angle with valid/ready.
// ----------------------------------------------------------------------------
interface dcmsm_res_if;
  import dcmsm_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [SPEED_W-1:0] speed;
  logic [ANGLE_W-1:0]        angle;

  modport source (output valid, output speed, output angle, input ready);
  modport sink   (input valid, input speed, input angle, output ready);
endinterface

// File: rtl/dcmsm_cfg_if.sv
// ----------------------------------------------------------------------------
// Configuration write channel
// Register index and write data with valid/ready.
// ----------------------------------------------------------------------------
interface dcmsm_cfg_if;
  import dcmsm_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/dcmsm_cfg.sv
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the filter gains, load term and angle gain; writes by index.
// ----------------------------------------------------------------------------
module dcmsm_cfg (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  dcmsm_cfg_if.sink             cfg_i,
  output dcmsm_pkg::cfg_regs_t  regs_o
);
  import dcmsm_pkg::*;

  cfg_regs_t regs_q, regs_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    regs_d = regs_q;
    if (cfg_i.valid) begin
      unique case (cfg_idx_e'(cfg_i.index))
        REG_FB_GAIN_ONE: regs_d.feedback_gain_one = $signed(cfg_i.data);
        REG_FB_GAIN_TWO: regs_d.feedback_gain_two = $signed(cfg_i.data);
        REG_DRIVE_GAIN:  regs_d.drive_gain        = cfg_i.data[DRIVE_W-1:0];
        REG_LOAD_OFFSET: regs_d.load_offset       = cfg_i.data[LOAD_W-1:0];
        REG_ANGLE_GAIN:  regs_d.angle_gain        = cfg_i.data[AGAIN_W-1:0];
        default: ; // drop writes to unknown indexes
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q <= CFG_RESET;
    end else begin
      regs_q <= regs_d;
    end
  end

  assign regs_o = regs_q;

endmodule

// File: rtl/dcmsm_speed.sv
// ----------------------------------------------------------------------------
// Speed stage
// Sample register, then the second-order recursion with rounding and
// saturation; the speed history lives here.
// ----------------------------------------------------------------------------
module dcmsm_speed (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  dcmsm_smp_if.sink            smp_i,
  input  dcmsm_pkg::cfg_regs_t cfg_i,
  output dcmsm_pkg::spd_req_t  spd_o,
  input  logic                 spd_ready_i
);
  import dcmsm_pkg::*;

  logic                   smp_vld_q;
  logic [SAMPLE_BITS-1:0] pos_q, neg_q;
  logic                   spd_vld_q;
  logic signed [SPEED_W-1:0] speed_last_q, speed_before_q, speed_d;

  logic smp_take, spd_load, spd_free;

  logic signed [DIFF_W-1:0]  diff;
  logic signed [63:0]        fb_one, fb_two;
  logic signed [DRV_W-1:0]   drv_prod;
  logic signed [SUM_W-1:0]   drv_ext, drv_term, load_term, rnd_sum;
  logic [SUM_W-62:0]         top_bits;

  assign spd_free    = !spd_vld_q || spd_ready_i;
  assign spd_load    = smp_vld_q && spd_free;
  assign smp_i.ready = !smp_vld_q || spd_free;
  assign smp_take    = smp_i.valid && smp_i.ready;

  assign diff     = $signed({1'b0, pos_q}) - $signed({1'b0, neg_q});
  assign fb_one   = 64'(cfg_i.feedback_gain_one) * 64'(speed_last_q);
  assign fb_two   = 64'(cfg_i.feedback_gain_two) * 64'(speed_before_q);
  assign drv_prod = DRV_W'($signed({1'b0, cfg_i.drive_gain})) * DRV_W'(diff);
  assign drv_ext  = SUM_W'(drv_prod);
  assign drv_term = $signed({drv_ext[SUM_W-11:0], 10'b0});
  assign load_term = -$signed({{(SUM_W-LOAD_W-30){1'b0}}, cfg_i.load_offset, 30'b0});

  // exact Q.50 sum, half-up rounding to Q.20
  assign rnd_sum = SUM_W'(fb_one) + SUM_W'(fb_two) + drv_term + load_term + SPD_RND;
  assign top_bits = rnd_sum[SUM_W-1:61];

  always_comb begin
    if ((&top_bits) || !(|top_bits)) begin
      speed_d = $signed(rnd_sum[61:30]);
    end else if (rnd_sum[SUM_W-1]) begin
      speed_d = SPEED_MIN;
    end else begin
      speed_d = SPEED_MAX;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smp_vld_q      <= 1'b0;
      spd_vld_q      <= 1'b0;
      speed_last_q   <= '0;
      speed_before_q <= '0;
    end else begin
      if (smp_i.ready) begin
        smp_vld_q <= smp_i.valid;
      end
      if (spd_free) begin
        spd_vld_q <= smp_vld_q;
      end
      // shift history as the item moves into the speed register
      if (spd_load) begin
        speed_last_q   <= speed_d;
        speed_before_q <= speed_last_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (smp_take) begin
      pos_q <= smp_i.pos_sample;
      neg_q <= smp_i.neg_sample;
    end
  end

  // the newest speed is the value waiting in the speed register
  assign spd_o.valid = spd_vld_q;
  assign spd_o.speed = speed_last_q;

endmodule

// File: rtl/dcmsm_angle.sv
// ----------------------------------------------------------------------------
// Angle stage
// Angle gain product register, then rounding and the wrapping angle
// accumulator, which also serves as the result register.
// ----------------------------------------------------------------------------
module dcmsm_angle (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dcmsm_pkg::cfg_regs_t cfg_i,
  input  dcmsm_pkg::spd_req_t  spd_i,
  output logic                 spd_ready_o,
  dcmsm_res_if.source          res_o
);
  import dcmsm_pkg::*;

  logic                      prd_vld_q;
  logic signed [PROD_W-1:0]  prod_q, prod_d, prod_rnd;
  logic signed [SPEED_W-1:0] prd_speed_q, out_speed_q;
  logic                      out_vld_q;
  logic [ANGLE_W-1:0]        angle_q, inc;
  logic                      out_free, prd_free, prd_load, out_load;

  assign out_free    = !out_vld_q || res_o.ready;
  assign prd_free    = !prd_vld_q || out_free;
  assign spd_ready_o = prd_free;
  assign prd_load    = spd_i.valid && prd_free;
  assign out_load    = prd_vld_q && out_free;

  assign prod_d   = PROD_W'($signed({1'b0, cfg_i.angle_gain})) * PROD_W'(spd_i.speed);
  // half-up rounding of the Q.64 product to Q.32
  assign prod_rnd = prod_q + ANG_RND;
  assign inc      = ANGLE_W'($signed(prod_rnd[PROD_W-1:32]));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prd_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
      angle_q   <= '0;
    end else begin
      if (prd_free) begin
        prd_vld_q <= spd_i.valid;
      end
      if (out_free) begin
        out_vld_q <= prd_vld_q;
      end
      if (out_load) begin
        angle_q <= angle_q + inc;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (prd_load) begin
      prod_q      <= prod_d;
      prd_speed_q <= spd_i.speed;
    end
    if (out_load) begin
      out_speed_q <= prd_speed_q;
    end
  end

  assign res_o.valid = out_vld_q;
  assign res_o.speed = out_speed_q;
  assign res_o.angle = angle_q;

endmodule

// File: rtl/dc_motor_speed_model_unit.sv
// ----------------------------------------------------------------------------
// DC motor speed model
// Second-order speed recursion driven by a terminal voltage difference,
// followed by a wrapping shaft angle integrator.
// ----------------------------------------------------------------------------
//  channel | dir | payload                          | transfer
//  smp_i   | in  | pos_sample, neg_sample           | valid && ready
//  res_o   | out | speed (Q11.20), angle (Q16.32)   | valid && ready
//  cfg_i   | in  | index, data                      | valid && ready (ready = 1)
//
// One sample pair per cycle while no stage holds; a result passes through the
// sample, speed, product and result registers after its request is accepted.
// Throughput is set by the combinational speed recursion (two 32x32 products
// and the rounded sum), which feeds its own history register.
// Reset clears the speed history, the angle and all valid flags, and loads
// the default gains. Each stage holds while the next is full and stalled,
// so a stalled result does not stop requests from filling the empty stages.
// ----------------------------------------------------------------------------
`include "dc_motor_speed_model_unit_assert.svh"

module dc_motor_speed_model_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  dcmsm_smp_if.sink    smp_i,
  dcmsm_res_if.source  res_o,
  dcmsm_cfg_if.sink    cfg_i
);
  import dcmsm_pkg::*;

  cfg_regs_t regs;
  spd_req_t  spd;
  logic      spd_ready;

  dcmsm_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .regs_o (regs)
  );

  dcmsm_speed u_speed (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .smp_i       (smp_i),
    .cfg_i       (regs),
    .spd_o       (spd),
    .spd_ready_i (spd_ready)
  );

  dcmsm_angle u_angle (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (regs),
    .spd_i       (spd),
    .spd_ready_o (spd_ready),
    .res_o       (res_o)
  );

  `DCMSM_ASSERT(a_spd_hold, spd.valid && !spd_ready |=> spd.valid && $stable(spd.speed), "speed stage lost or changed a stalled value")
  `DCMSM_ASSERT(a_empty_out_ready, !res_o.valid |-> smp_i.ready, "input stalled with an empty result register")
  `DCMSM_ASSERT_ALWAYS(a_reset_empty, !rst_ni |-> !res_o.valid && !spd.valid, "pipeline not empty in reset")

endmodule
